[hw/rtl/fgne_pkg.sv]
package fgne_pkg;

    localparam int PIX_W       = 8;
    localparam int NPIX        = 9;
    localparam int CENTER_IDX  = 4;
    localparam int BOX_W       = 12;
    localparam int DEV_W       = 16;
    localparam int RESID_W     = 11;
    localparam int RSQ_W       = 22;
    localparam int MEAN_W      = 16;
    localparam int SIGMA_W     = 15;
    localparam int FLAT_W      = 13;
    localparam int LIMIT_W     = 15;
    localparam int THRESH_W    = 16;
    localparam int QUOT_W      = 28;
    localparam int MEAN_STEPS  = 16;
    localparam int SIG_STEPS   = 28;
    localparam int SQRT_STEPS  = 14;
    localparam int STEP_W      = 5;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [SIGMA_W-1:0]  SIGMA_SAT       = 15'd25600;
    localparam logic [LIMIT_W-1:0]  FLAT_LIMIT_RST  = 15'd486;
    localparam logic [THRESH_W-1:0] CUT_THRESH_RST  = 16'd4608;
    localparam logic [FLAT_W-1:0]   MIN_FLAT_RST    = 13'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FLAT_LIMIT = 2'd0,
        REG_CUT_THRESH = 2'd1,
        REG_MIN_FLAT   = 2'd2
    } cfg_reg_t;

    // controller to datapath
    typedef struct packed {
        logic accept_en;
        logic mean_load;
        logic div_step;
        logic sig_load;
        logic sqrt_load;
        logic sqrt_step;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_acc;
        logic out_busy;
    } dp_status_t;

endpackage

[hw/rtl/fgne_ctrl.sv]
module fgne_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_accept,
    input  logic                 in_last,
    input  fgne_pkg::dp_status_t status,
    output fgne_pkg::dp_cmd_t    cmd
);
    import fgne_pkg::*;

    typedef enum logic [8:0] {
        ST_ACC       = 9'b000000001,
        ST_DRAIN     = 9'b000000010,
        ST_MEAN_INIT = 9'b000000100,
        ST_MEAN_DIV  = 9'b000001000,
        ST_SIG_INIT  = 9'b000010000,
        ST_SIG_DIV   = 9'b000100000,
        ST_SQRT_INIT = 9'b001000000,
        ST_SQRT      = 9'b010000000,
        ST_DONE      = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_ACC:
            begin
                cmd.accept_en = 1'b1;
                if (in_accept && in_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.last_acc)
                begin
                    state_next = ST_MEAN_INIT;
                end
            end
            ST_MEAN_INIT:
            begin
                cmd.mean_load = 1'b1;
                step_next     = STEP_W'(MEAN_STEPS - 1);
                state_next    = ST_MEAN_DIV;
            end
            ST_MEAN_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_SIG_INIT;
                end
            end
            ST_SIG_INIT:
            begin
                cmd.sig_load = 1'b1;
                step_next    = STEP_W'(SIG_STEPS - 1);
                state_next   = ST_SIG_DIV;
            end
            ST_SIG_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_SQRT_INIT;
                end
            end
            ST_SQRT_INIT:
            begin
                cmd.sqrt_load = 1'b1;
                step_next     = STEP_W'(SQRT_STEPS - 1);
                state_next    = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the previous result has left the output register
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

[hw/rtl/fgne_dp.sv]
module fgne_dp #(
    parameter int MAX_WINDOWS = 4096
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fgne_pkg::dp_cmd_t                     cmd,
    output fgne_pkg::dp_status_t                  status,
    input  logic                                  in_accept,
    input  logic [fgne_pkg::IN_TDATA_W-1:0]       in_data,
    input  logic                                  in_last,
    input  logic                                  cfg_we,
    input  logic [fgne_pkg::CFG_IDX_W-1:0]        cfg_idx,
    input  logic [fgne_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [fgne_pkg::OUT_TDATA_W-1:0]      out_data,
    output logic [fgne_pkg::OUT_TUSER_W-1:0]      out_user
);
    import fgne_pkg::*;

    localparam int CNT_W  = $clog2(MAX_WINDOWS + 1);
    localparam int CSUM_W = CNT_W + PIX_W;
    localparam int RES_W  = CNT_W + RSQ_W;
    localparam int DIV_W  = CNT_W + 7;
    localparam int REM_W  = DIV_W + 1;
    localparam int CMP_W  = (CNT_W > FLAT_W) ? CNT_W : FLAT_W;

    // configuration
    logic [LIMIT_W-1:0]  flat_limit_reg;
    logic [THRESH_W-1:0] cut_thresh_reg;
    logic [FLAT_W-1:0]   min_flat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flat_limit_reg <= FLAT_LIMIT_RST;
            cut_thresh_reg <= CUT_THRESH_RST;
            min_flat_reg   <= MIN_FLAT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_FLAT_LIMIT: flat_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                REG_CUT_THRESH: cut_thresh_reg <= cfg_wdata[THRESH_W-1:0];
                REG_MIN_FLAT:   min_flat_reg   <= cfg_wdata[FLAT_W-1:0];
                default:        ;
            endcase
        end
    end

    // window pipeline: box sum, deviations, flatness test and square
    logic                 s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                 s1_last_reg, s2_last_reg, s3_last_reg;
    logic [PIX_W-1:0]     s1_pix_reg [NPIX];
    logic [BOX_W-1:0]     s1_box_reg;
    logic [BOX_W-1:0]     s2_dev_reg [NPIX];
    logic [PIX_W-1:0]     s2_center_reg, s3_center_reg;
    logic                 s3_flat_reg;
    logic [RSQ_W-1:0]     s3_rsq_reg;
    logic [BOX_W-1:0]     box_next;
    logic [BOX_W-1:0]     dev_next [NPIX];
    logic [DEV_W-1:0]     dev_sum;
    logic [RESID_W-1:0]   resid;

    always_comb
    begin
        box_next = '0;
        for (int i = 0; i < NPIX; i++)
        begin
            box_next = box_next + BOX_W'(in_data[i*PIX_W +: PIX_W]);
        end
    end

    always_comb
    begin
        logic [BOX_W-1:0] s9;
        for (int i = 0; i < NPIX; i++)
        begin
            s9 = {1'b0, s1_pix_reg[i], 3'b000} + BOX_W'(s1_pix_reg[i]);
            dev_next[i] = (s9 >= s1_box_reg) ? (s9 - s1_box_reg) : (s1_box_reg - s9);
        end
    end

    always_comb
    begin
        dev_sum = '0;
        for (int i = 0; i < NPIX; i++)
        begin
            dev_sum = dev_sum + DEV_W'(s2_dev_reg[i]);
        end
    end

    assign resid = s2_dev_reg[CENTER_IDX][RESID_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            for (int i = 0; i < NPIX; i++)
            begin
                s1_pix_reg[i] <= in_data[i*PIX_W +: PIX_W];
            end
            s1_box_reg  <= box_next;
            s1_last_reg <= in_last;
        end
        if (s1_valid_reg)
        begin
            s2_dev_reg    <= dev_next;
            s2_center_reg <= s1_pix_reg[CENTER_IDX];
            s2_last_reg   <= s1_last_reg;
        end
        if (s2_valid_reg)
        begin
            s3_flat_reg   <= ({1'b0, dev_sum} <= (DEV_W + 1)'(flat_limit_reg));
            s3_rsq_reg    <= RSQ_W'(resid) * RSQ_W'(resid);
            s3_center_reg <= s2_center_reg;
            s3_last_reg   <= s2_last_reg;
        end
    end

    // frame sums
    logic [CSUM_W-1:0] csum_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  flat_reg;
    logic [RES_W-1:0]  res_reg;
    logic [MEAN_W-1:0] prev_mean_reg;
    logic              have_prev_reg;

    assign status.last_acc = s3_valid_reg && s3_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            csum_reg  <= '0;
            count_reg <= '0;
            flat_reg  <= '0;
            res_reg   <= '0;
        end
        else if (cmd.out_load)
        begin
            csum_reg  <= '0;
            count_reg <= '0;
            flat_reg  <= '0;
            res_reg   <= '0;
        end
        else if (s3_valid_reg && (count_reg < CNT_W'(MAX_WINDOWS)))
        begin
            csum_reg  <= csum_reg + CSUM_W'(s3_center_reg);
            count_reg <= count_reg + 1'b1;
            if (s3_flat_reg)
            begin
                res_reg  <= res_reg + RES_W'(s3_rsq_reg);
                flat_reg <= flat_reg + 1'b1;
            end
        end
    end

    // shared restoring divider, quotient known to fit QUOT_W bits
    logic [REM_W-1:0]  rem_reg;
    logic [QUOT_W-1:0] low_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [DIV_W-1:0]  divisor_reg;
    logic [MEAN_W-1:0] mean_reg;
    logic [REM_W-1:0]  trial;
    logic              trial_ok;

    assign trial    = {rem_reg[REM_W-2:0], low_reg[QUOT_W-1]};
    assign trial_ok = trial >= REM_W'(divisor_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mean_load)
        begin
            rem_reg     <= REM_W'(csum_reg[CSUM_W-1:PIX_W]);
            low_reg     <= {csum_reg[PIX_W-1:0], (QUOT_W - PIX_W)'(0)};
            divisor_reg <= DIV_W'(count_reg);
        end
        else if (cmd.sig_load)
        begin
            rem_reg     <= REM_W'(res_reg[RES_W-1:16]);
            low_reg     <= {res_reg[15:0], 12'd0};
            divisor_reg <= DIV_W'(flat_reg) * DIV_W'(81);
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= trial_ok ? (trial - REM_W'(divisor_reg)) : trial;
            low_reg  <= {low_reg[QUOT_W-2:0], 1'b0};
            quot_reg <= {quot_reg[QUOT_W-2:0], trial_ok};
        end
        if (cmd.sig_load)
        begin
            mean_reg <= (count_reg == '0) ? '0 : quot_reg[MEAN_W-1:0];
        end
    end

    // bitwise integer square root
    logic [QUOT_W-1:0] sq_v_reg;
    logic [QUOT_W-1:0] sq_root_reg;
    logic [QUOT_W-1:0] sq_bit_reg;
    logic [QUOT_W:0]   sq_trial;
    logic              sq_ok;

    assign sq_trial = {1'b0, sq_root_reg} + {1'b0, sq_bit_reg};
    assign sq_ok    = {1'b0, sq_v_reg} >= sq_trial;

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_load)
        begin
            sq_v_reg    <= quot_reg;
            sq_root_reg <= '0;
            sq_bit_reg  <= QUOT_W'(1) << (QUOT_W - 2);
        end
        else if (cmd.sqrt_step)
        begin
            if (sq_ok)
            begin
                sq_v_reg    <= sq_v_reg - sq_trial[QUOT_W-1:0];
                sq_root_reg <= (sq_root_reg >> 1) + sq_bit_reg;
            end
            else
            begin
                sq_root_reg <= sq_root_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
    end

    // result
    logic [SIGMA_W-1:0]  sigma;
    logic [MEAN_W-1:0]   mean_diff;
    logic                cut;
    logic                sig_valid;
    logic                out_valid_reg;
    logic [MEAN_W-1:0]   out_mean_reg;
    logic [SIGMA_W-1:0]  out_sigma_reg;
    logic [FLAT_W-1:0]   out_flat_reg;
    logic                out_sig_valid_reg;
    logic                out_cut_reg;

    always_comb
    begin
        if (flat_reg == '0)
        begin
            sigma = '0;
        end
        else if (sq_root_reg > QUOT_W'(SIGMA_SAT))
        begin
            sigma = SIGMA_SAT;
        end
        else
        begin
            sigma = sq_root_reg[SIGMA_W-1:0];
        end
    end

    assign mean_diff = (mean_reg >= prev_mean_reg) ? (mean_reg - prev_mean_reg)
                                                   : (prev_mean_reg - mean_reg);
    assign cut       = !have_prev_reg || (mean_diff >= cut_thresh_reg);
    assign sig_valid = CMP_W'(flat_reg) >= CMP_W'(min_flat_reg);

    assign status.out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            prev_mean_reg <= '0;
            have_prev_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
            prev_mean_reg <= mean_reg;
            have_prev_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_mean_reg      <= mean_reg;
            out_sigma_reg     <= sigma;
            out_flat_reg      <= FLAT_W'(flat_reg);
            out_sig_valid_reg <= sig_valid;
            out_cut_reg       <= cut;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {4'b0000, out_flat_reg, out_sigma_reg, out_mean_reg};
    assign out_user  = {out_cut_reg, out_sig_valid_reg};

endmodule

[hw/rtl/frame_grain_noise_estimator_top.sv]
// frame grain noise estimator
// s_axis carries one sampled 3x3 luma window per beat, tlast on the final
// window of a frame. windows are accumulated through a four stage pipeline;
// a frame ends with one beat on m_axis holding the mean luma, the noise sigma
// and its flags. non-last windows produce no output.
// throughput: one window per cycle inside a frame. after a tlast beat
// s_axis_tready stays low through a pipeline drain, a 16 step mean divide, a
// 28 step residual divide and a 14 step square root (each after its own
// load), and an output load, all on one shared shift-subtract divider and
// one root unit.
// the result sits in an output register, so the next frame streams in while
// it waits; if the sink still stalls when the following frame ends, the block
// holds that result and keeps s_axis_tready low until the register frees.
// cfg writes (index 0 flatness limit, 1 cut threshold, 2 minimum flat count)
// are always ready and must only happen between frames.
// reset clears all sums, restores register defaults and makes the next
// frame report a scene cut.
module frame_grain_noise_estimator_top #(
    parameter int MAX_WINDOWS = 4096
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // pix_up_left, pix_up, pix_up_right, pix_left, pix_center, pix_right,
    // pix_down_left, pix_down, pix_down_right
    input  logic [fgne_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    input  logic                                  s_axis_tlast,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // mean_luma_q8, sigma_q6, flat_windows, zero pad
    output logic [fgne_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // sigma_valid, scene_cut
    output logic [fgne_pkg::OUT_TUSER_W-1:0]      m_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fgne_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fgne_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import fgne_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_accept;

    assign s_axis_tready = cmd.accept_en;
    assign in_accept     = s_axis_tvalid && cmd.accept_en;
    assign cfg_ready     = 1'b1;

    fgne_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_last   (s_axis_tlast),
        .status    (status),
        .cmd       (cmd)
    );

    fgne_dp #(
        .MAX_WINDOWS (MAX_WINDOWS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_accept (in_accept),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .cfg_we    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule
